### src/cnps_pkg.sv
// Shared types, constants and arithmetic helpers for the complex Newton step block.
// Used by complex_newton_polynomial_step; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package cnps_pkg;

  // Highest polynomial power that is evaluated (1 to 5).
  localparam int DEGREE = 5;
  // Coefficient registers that exist, whatever DEGREE is.
  localparam int NUM_COEF = 6;
  localparam int COEF_IDX_W = 3;
  localparam int CFG_IDX_W = 8;

  // Register indexes; 0 up to NUM_COEF-1 are the coefficients.
  localparam logic [CFG_IDX_W-1:0] REG_BAD_LIMIT   = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_LIMIT = CFG_IDX_W'(7);

  localparam logic [61:0] BAD_LIMIT_RESET   = 62'd83886080;
  localparam logic [61:0] SMALL_LIMIT_RESET = 62'd16777;
  localparam logic [61:0] BAD_SQ_RESET      = BAD_LIMIT_RESET * BAD_LIMIT_RESET;
  localparam logic [61:0] SMALL_SQ_RESET    = SMALL_LIMIT_RESET * SMALL_LIMIT_RESET;

  typedef struct packed {
    logic signed [31:0] guess_real;
    logic signed [31:0] guess_imag;
  } cnps_in_t;

  typedef struct packed {
    logic signed [31:0] next_real;
    logic signed [31:0] next_imag;
    logic               bad_step;
    logic               converged_step;
  } cnps_out_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // round((p1 + p2) / 2^24), ties upward, plus c, saturated.
  function automatic logic signed [31:0] mac2(input logic signed [63:0] p1,
                                              input logic signed [63:0] p2,
                                              input logic signed [31:0] c);
    logic signed [65:0] s;
    logic signed [65:0] h;
    s = 66'(p1) + 66'(p2) + 66'sd8388608;
    h = (s >>> 24) + 66'(c);
    return sat32(h);
  endfunction

  // k * c for the derivative coefficients, saturated.
  function automatic logic signed [31:0] dscale(input logic [COEF_IDX_W-1:0] k,
                                                input logic signed [31:0] c);
    logic signed [65:0] p;
    p = 66'(c) * 66'($signed({1'b0, k}));
    return sat32(p);
  endfunction

  // One restoring division step: shift in the top dividend bit, subtract if it fits.
  function automatic logic [95:0] div_step(input logic [63:0] rem,
                                           input logic [31:0] sh,
                                           input logic [63:0] den);
    logic [64:0] t;
    logic        b;
    t = {rem, sh[31]};
    b = (t >= {1'b0, den});
    if (b) begin
      t = t - {1'b0, den};
    end
    return {t[63:0], sh[30:0], b};
  endfunction

  // Applies the sign to a quotient magnitude and clamps to the signed range.
  function automatic logic signed [31:0] qsign(input logic [31:0] mag, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      r = (mag > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-mag);
    end else begin
      r = (mag > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/complex_newton_polynomial_step.sv
// Top level of the complex Newton step: Horner evaluation, pipelined divider, limits.
// Depends on cnps_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One Newton step z - P(z)/P'(z) per complex guess in Q8.24. The block takes a new
// word every cycle while the output is not stalled. The pipeline holds the Horner
// chain, a multiply stage and a rounding stage for each power, and the
// 32-stage restoring divider that produces one quotient bit per stage. A stalled
// output word freezes the whole pipeline, and nothing is dropped or repeated.
// The user must write coefficient and limit registers through the configuration
// port while no word is in flight; the block itself does not enforce this.
// The configuration port is always ready.
module complex_newton_polynomial_step import cnps_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire cnps_in_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output cnps_out_t                 out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);

  localparam int DIV_BITS = 32;

  typedef struct packed {
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic signed [31:0] pr;
    logic signed [31:0] pi;
    logic signed [31:0] dr;
    logic signed [31:0] di;
  } hv_t;

  typedef struct packed {
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic signed [31:0] dr;
    logic signed [31:0] di;
    logic signed [63:0] prr;
    logic signed [63:0] pii;
    logic signed [63:0] pri;
    logic signed [63:0] pir;
    logic signed [63:0] drr;
    logic signed [63:0] dii;
    logic signed [63:0] dri;
    logic signed [63:0] dir;
  } hp_t;

  typedef struct packed {
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic               zero;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [63:0] pidr;
    logic signed [63:0] prdi;
    logic signed [63:0] drdr;
    logic signed [63:0] didi;
  } mp_t;

  typedef struct packed {
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic               zero;
    logic [63:0]        mag_r;
    logic               neg_r;
    logic [63:0]        mag_i;
    logic               neg_i;
    logic [63:0]        den;
  } nm_t;

  typedef struct packed {
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic               zero;
    logic [63:0]        den;
    logic [63:0]        rem_r;
    logic [31:0]        sh_r;
    logic               neg_r;
    logic               ovf_r;
    logic [63:0]        rem_i;
    logic [31:0]        sh_i;
    logic               neg_i;
    logic               ovf_i;
  } dv_t;

  typedef struct packed {
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic               zero;
    logic signed [31:0] qr;
    logic signed [31:0] qi;
  } fq_t;

  typedef struct packed {
    logic               zero;
    logic [63:0]        q2;
    logic signed [31:0] res_r;
    logic signed [31:0] res_i;
  } fs_t;

  // Configuration registers. The limits are kept squared.
  logic signed [31:0] coef_q  [NUM_COEF];
  logic signed [31:0] dcoef_q [NUM_COEF];
  logic [61:0]        bad_sq_q;
  logic [61:0]        small_sq_q;

  logic en;
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_q[i]  <= '0;
        dcoef_q[i] <= '0;
      end
      bad_sq_q   <= BAD_SQ_RESET;
      small_sq_q <= SMALL_SQ_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i < CFG_IDX_W'(NUM_COEF)) begin
        coef_q[cfg_index_i[COEF_IDX_W-1:0]]  <= $signed(cfg_data_i);
        dcoef_q[cfg_index_i[COEF_IDX_W-1:0]] <=
          dscale(cfg_index_i[COEF_IDX_W-1:0], $signed(cfg_data_i));
      end else if (cfg_index_i == REG_BAD_LIMIT) begin
        bad_sq_q <= 62'(cfg_data_i[30:0]) * 62'(cfg_data_i[30:0]);
      end else if (cfg_index_i == REG_SMALL_LIMIT) begin
        small_sq_q <= 62'(cfg_data_i[30:0]) * 62'(cfg_data_i[30:0]);
      end
    end
  end

  // Entry stage: the guess and the leading coefficients of P and P'.
  hv_t  s0_q;
  logic s0_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q.zr <= in_data_i.guess_real;
      s0_q.zi <= in_data_i.guess_imag;
      s0_q.pr <= coef_q[DEGREE];
      s0_q.pi <= '0;
      s0_q.dr <= dcoef_q[DEGREE];
      s0_q.di <= '0;
    end
  end

  // Horner chain: each power gets a multiply stage and a round-and-add stage.
  // P' runs one step shorter, so on the last step it passes through.
  hv_t  hb_w   [DEGREE];
  logic hb_v_w [DEGREE];

  for (genvar j = 0; j < DEGREE; j++) begin : g_horner
    localparam int K = DEGREE - 1 - j;
    hv_t  hin;
    logic hin_v;
    hp_t  ha_q;
    logic ha_v_q;
    hv_t  hb_q;
    logic hb_v_q;

    if (j == 0) begin : g_first
      assign hin   = s0_q;
      assign hin_v = s0_v_q;
    end else begin : g_next
      assign hin   = hb_w[j-1];
      assign hin_v = hb_v_w[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ha_v_q <= 1'b0;
        hb_v_q <= 1'b0;
      end else if (en) begin
        ha_v_q <= hin_v;
        hb_v_q <= ha_v_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ha_q.zr  <= hin.zr;
        ha_q.zi  <= hin.zi;
        ha_q.dr  <= hin.dr;
        ha_q.di  <= hin.di;
        ha_q.prr <= 64'(hin.pr) * 64'(hin.zr);
        ha_q.pii <= 64'(hin.pi) * 64'(hin.zi);
        ha_q.pri <= 64'(hin.pr) * 64'(hin.zi);
        ha_q.pir <= 64'(hin.pi) * 64'(hin.zr);
        ha_q.drr <= 64'(hin.dr) * 64'(hin.zr);
        ha_q.dii <= 64'(hin.di) * 64'(hin.zi);
        ha_q.dri <= 64'(hin.dr) * 64'(hin.zi);
        ha_q.dir <= 64'(hin.di) * 64'(hin.zr);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        hb_q.zr <= ha_q.zr;
        hb_q.zi <= ha_q.zi;
        hb_q.pr <= mac2(ha_q.prr, -ha_q.pii, coef_q[K]);
        hb_q.pi <= mac2(ha_q.pri, ha_q.pir, '0);
        if (K >= 1) begin
          hb_q.dr <= mac2(ha_q.drr, -ha_q.dii, dcoef_q[K]);
          hb_q.di <= mac2(ha_q.dri, ha_q.dir, '0);
        end else begin
          hb_q.dr <= ha_q.dr;
          hb_q.di <= ha_q.di;
        end
      end
    end

    assign hb_w[j]   = hb_q;
    assign hb_v_w[j] = hb_v_q;
  end

  // Products for q = P * conj(P') / |P'|^2.
  hv_t  hl;
  mp_t  mp_q;
  logic mp_v_q;
  nm_t  nm_q;
  logic nm_v_q;
  assign hl = hb_w[DEGREE-1];

  logic signed [64:0] nr_sum;
  logic signed [64:0] ni_sum;
  assign nr_sum = 65'(mp_q.p1) + 65'(mp_q.p2);
  assign ni_sum = 65'(mp_q.pidr) - 65'(mp_q.prdi);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mp_q.zr   <= hl.zr;
      mp_q.zi   <= hl.zi;
      mp_q.zero <= (hl.dr == '0) && (hl.di == '0);
      mp_q.p1   <= 64'(hl.pr) * 64'(hl.dr);
      mp_q.p2   <= 64'(hl.pi) * 64'(hl.di);
      mp_q.pidr <= 64'(hl.pi) * 64'(hl.dr);
      mp_q.prdi <= 64'(hl.pr) * 64'(hl.di);
      mp_q.drdr <= 64'(hl.dr) * 64'(hl.dr);
      mp_q.didi <= 64'(hl.di) * 64'(hl.di);

      nm_q.zr    <= mp_q.zr;
      nm_q.zi    <= mp_q.zi;
      nm_q.zero  <= mp_q.zero;
      nm_q.neg_r <= nr_sum[64];
      nm_q.mag_r <= nr_sum[64] ? 64'(-nr_sum) : nr_sum[63:0];
      nm_q.neg_i <= ni_sum[64];
      nm_q.mag_i <= ni_sum[64] ? 64'(-ni_sum) : ni_sum[63:0];
      nm_q.den   <= $unsigned(mp_q.drdr) + $unsigned(mp_q.didi);
    end
  end

  // Divider: stage zero checks for an integer part of 256 or more and loads the
  // remainder; each later stage settles one quotient bit.
  dv_t  dv_w   [DIV_BITS+1];
  logic dv_v_w [DIV_BITS+1];
  dv_t  dv0_q;
  logic dv0_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv0_q.zr    <= nm_q.zr;
      dv0_q.zi    <= nm_q.zi;
      dv0_q.zero  <= nm_q.zero;
      dv0_q.den   <= nm_q.den;
      dv0_q.neg_r <= nm_q.neg_r;
      dv0_q.ovf_r <= {8'd0, nm_q.mag_r} >= {nm_q.den, 8'd0};
      dv0_q.rem_r <= {8'd0, nm_q.mag_r[63:8]};
      dv0_q.sh_r  <= {nm_q.mag_r[7:0], 24'd0};
      dv0_q.neg_i <= nm_q.neg_i;
      dv0_q.ovf_i <= {8'd0, nm_q.mag_i} >= {nm_q.den, 8'd0};
      dv0_q.rem_i <= {8'd0, nm_q.mag_i[63:8]};
      dv0_q.sh_i  <= {nm_q.mag_i[7:0], 24'd0};
    end
  end

  assign dv_w[0]   = dv0_q;
  assign dv_v_w[0] = dv0_v_q;

  for (genvar b = 1; b <= DIV_BITS; b++) begin : g_div
    dv_t         dq;
    logic        dv_v_q;
    logic [95:0] step_r;
    logic [95:0] step_i;

    assign step_r = div_step(dv_w[b-1].rem_r, dv_w[b-1].sh_r, dv_w[b-1].den);
    assign step_i = div_step(dv_w[b-1].rem_i, dv_w[b-1].sh_i, dv_w[b-1].den);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q <= 1'b0;
      end else if (en) begin
        dv_v_q <= dv_v_w[b-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dq.zr    <= dv_w[b-1].zr;
        dq.zi    <= dv_w[b-1].zi;
        dq.zero  <= dv_w[b-1].zero;
        dq.den   <= dv_w[b-1].den;
        dq.neg_r <= dv_w[b-1].neg_r;
        dq.ovf_r <= dv_w[b-1].ovf_r;
        dq.neg_i <= dv_w[b-1].neg_i;
        dq.ovf_i <= dv_w[b-1].ovf_i;
        dq.rem_r <= step_r[95:32];
        dq.sh_r  <= step_r[31:0];
        dq.rem_i <= step_i[95:32];
        dq.sh_i  <= step_i[31:0];
      end
    end

    assign dv_w[b]   = dq;
    assign dv_v_w[b] = dv_v_q;
  end

  // Final stages: signed quotient, squared step and new guess, then the limit checks.
  dv_t  dl;
  fq_t  fq_q;
  logic fq_v_q;
  fs_t  fs_q;
  logic fs_v_q;
  cnps_out_t out_q;
  logic      out_v_q;
  logic      bad;
  assign dl = dv_w[DIV_BITS];

  assign bad = fs_q.zero || (fs_q.q2 > {2'd0, bad_sq_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      fq_q.zr   <= dl.zr;
      fq_q.zi   <= dl.zi;
      fq_q.zero <= dl.zero;
      fq_q.qr   <= qsign(dl.ovf_r ? 32'hFFFF_FFFF : dl.sh_r, dl.neg_r);
      fq_q.qi   <= qsign(dl.ovf_i ? 32'hFFFF_FFFF : dl.sh_i, dl.neg_i);

      fs_q.zero  <= fq_q.zero;
      fs_q.q2    <= $unsigned(64'(fq_q.qr) * 64'(fq_q.qr)) +
                    $unsigned(64'(fq_q.qi) * 64'(fq_q.qi));
      fs_q.res_r <= sat32(66'(fq_q.zr) - 66'(fq_q.qr));
      fs_q.res_i <= sat32(66'(fq_q.zi) - 66'(fq_q.qi));

      out_q.bad_step       <= bad;
      out_q.converged_step <= !bad && (fs_q.q2 < {2'd0, small_sq_q});
      out_q.next_real      <= bad ? '0 : fs_q.res_r;
      out_q.next_imag      <= bad ? '0 : fs_q.res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_v_q  <= 1'b0;
      nm_v_q  <= 1'b0;
      dv0_v_q <= 1'b0;
      fq_v_q  <= 1'b0;
      fs_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      mp_v_q  <= hb_v_w[DEGREE-1];
      nm_v_q  <= mp_v_q;
      dv0_v_q <= nm_v_q;
      fq_v_q  <= dv_v_w[DIV_BITS];
      fs_v_q  <= fq_v_q;
      out_v_q <= fs_v_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // The remainder stays below the divisor whenever the quotient fits.
  a_div_rem_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_w[DIV_BITS] && !dl.zero && !dl.ovf_r |-> dl.rem_r < dl.den)
    else $error("real remainder not below divisor");

  a_div_rem_imag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_w[DIV_BITS] && !dl.zero && !dl.ovf_i |-> dl.rem_i < dl.den)
    else $error("imaginary remainder not below divisor");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.bad_step && out_data_o.converged_step))
    else $error("bad and converged both set");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_step |->
      out_data_o.next_real == '0 && out_data_o.next_imag == '0)
    else $error("bad step word carries a nonzero guess");

endmodule

`default_nettype wire
